// ===== src/fbft_pkg.sv =====
`timescale 1ns / 1ps

package fbft_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam int DATA_W     = 8;
  localparam int CMP_W      = 16;
  // Bits left after the start bit: data, parity, stop.
  localparam int TAIL_BITS  = DATA_W + 2;
  localparam int CNT_W      = $clog2(TAIL_BITS);

  localparam logic [CMP_W-1:0] RESET_BRIGHT = 16'd1999;
  localparam logic [CMP_W-1:0] RESET_DARK   = 16'd6999;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DARK   = 1'd1;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_LOAD
  } fbft_state_t;

  typedef struct packed {
    logic load_frame;  // latch frame tail, push start bit
    logic push;        // push next tail bit
    logic pop;         // read head bit, advance read pointer
    logic load_out;    // move read bit into output register
  } fbft_cmd_t;

  typedef struct packed {
    logic empty;
    logic out_busy;
  } fbft_status_t;

endpackage

// ===== src/framed_byte_bit_fifo_transmitter.sv =====
`timescale 1ns / 1ps
// Add-byte word: one frame bit written per cycle into the
//   single-port bit store (start bit on the accept cycle, then 10 more).
// Tick word: if the FIFO is not empty, the result passes the registered store
//   read, then the output register; ticks stall while a result is still held.
// Reset (rst_n low, synchronous): pointers cleared (FIFO empty), compare
//   registers to 1999 / 6999, controller idle, no result pending.

module framed_byte_bit_fifo_transmitter import fbft_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  logic [DATA_W-1:0]    in_data_byte,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_line_bit,
  output logic [CMP_W-1:0]     out_compare_value,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CMP_W-1:0]     cfg_wdata
);

  fbft_cmd_t    cmd;
  fbft_status_t status;

  // Sequencer: decodes the word kind, walks the frame tail, times the pop.
  fbft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Bit store, pointers, frame shifter, compare registers, output register.
  // A full store drops each frame bit on its own; one slot stays free.
  fbft_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_data_byte      (in_data_byte),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_line_bit      (out_line_bit),
    .out_compare_value (out_compare_value)
  );

endmodule

// ===== src/fbft_ctrl.sv =====
`timescale 1ns / 1ps

module fbft_ctrl import fbft_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_kind,
  output logic         in_stall,
  input  fbft_status_t status,
  output fbft_cmd_t    cmd
);

  fbft_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Ticks wait while a result is still held.
  assign in_stall = (state_r != ST_IDLE) || ((in_kind == KIND_TICK) && status.out_busy);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_ADD) begin
            cmd.load_frame = 1'b1;
            cnt_nxt        = '0;
            state_nxt      = ST_PUSH;
          end else if (!status.empty) begin
            cmd.pop   = 1'b1;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TAIL_BITS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOAD: begin
        cmd.load_out = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/fbft_dp.sv =====
`timescale 1ns / 1ps

module fbft_dp import fbft_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fbft_cmd_t            cmd,
  output fbft_status_t         status,
  input  logic [DATA_W-1:0]    in_data_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CMP_W-1:0]     cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_line_bit,
  output logic [CMP_W-1:0]     out_compare_value
);

  logic                 mem [FIFO_DEPTH];
  logic [PTR_W-1:0]     wp_r, rp_r;
  logic [PTR_W-1:0]     wp_inc, rp_inc;
  logic [TAIL_BITS-1:0] tail_r;
  logic [CMP_W-1:0]     bright_r, dark_r;
  logic                 rd_bit_r;
  logic                 out_valid_r;
  logic                 out_bit_r;
  logic [CMP_W-1:0]     out_cmp_r;
  logic                 full;
  logic                 wr_en;
  logic                 wr_bit;

  assign wp_inc = (wp_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign full   = (wp_inc == rp_r);

  assign status.empty    = (wp_r == rp_r);
  assign status.out_busy = out_valid_r;

  // Start bit 0 goes on the line inverted as 1.
  assign wr_bit = cmd.load_frame ? 1'b1 : tail_r[0];
  assign wr_en  = (cmd.load_frame || cmd.push) && !full;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_bit;
    end
    if (cmd.pop) begin
      rd_bit_r <= mem[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_inc;
      if (cmd.pop) rp_r <= rp_inc;
    end
  end

  // Inverted tail: data LSB first, even parity, stop.
  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      tail_r <= ~{1'b1, ^in_data_byte, in_data_byte};
    end else if (cmd.push) begin
      tail_r <= {1'b0, tail_r[TAIL_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= RESET_BRIGHT;
      dark_r   <= RESET_DARK;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BRIGHT: bright_r <= cfg_wdata;
        REG_DARK:   dark_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_bit_r <= rd_bit_r;
      out_cmp_r <= rd_bit_r ? bright_r : dark_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_bit      = out_bit_r;
  assign out_compare_value = out_cmp_r;

endmodule

// ===== bench/tb_framed_byte_bit_fifo_transmitter.sv =====
`timescale 1ns / 1ps

module tb_framed_byte_bit_fifo_transmitter;
  import fbft_pkg::*;

  // Slack after the last result: an add word keeps writing frame bits after
  // its accept, and a tick still passes the store read and the output register.
  localparam int SETTLE_CYCLES = 16;
  // Receiver hold-off long enough to back the block up into its input.
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_CYCLES  = 400000;

  // How a directed row is checked: against the predictor, or against a
  // typed-in outcome (no result, or one given result).
  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_NONE,
    CHK_PULSE
  } row_check_t;

  typedef struct packed {
    logic             line_bit;
    logic [CMP_W-1:0] compare_value;
  } pulse_t;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] data_byte;
    row_check_t        chk;
    pulse_t            pulse;
  } dir_row_t;

  localparam int DIR_N = 20;

  // Reset compares apply throughout the table. Inverted frame of 0x00 is
  // 1 (start), 1 x8 (data), 1 (parity), 0 (stop).
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{KIND_TICK, 8'h00, CHK_NONE,  '{1'b0, 16'd0}},     // tick on empty FIFO after reset
    '{KIND_ADD,  8'h00, CHK_NONE,  '{1'b0, 16'd0}},
    '{KIND_TICK, 8'h00, CHK_PULSE, '{1'b1, 16'd1999}},  // start bit, inverted
    '{KIND_TICK, 8'hFF, CHK_PULSE, '{1'b1, 16'd1999}},  // data ignored on a tick
    '{KIND_ADD,  8'hFF, CHK_NONE,  '{1'b0, 16'd0}},
    '{KIND_ADD,  8'h80, CHK_NONE,  '{1'b0, 16'd0}},
    '{KIND_ADD,  8'h01, CHK_NONE,  '{1'b0, 16'd0}},
    '{KIND_ADD,  8'h55, CHK_NONE,  '{1'b0, 16'd0}},
    '{KIND_ADD,  8'hAA, CHK_NONE,  '{1'b0, 16'd0}},
    '{KIND_TICK, 8'h00, CHK_PRED,  '{1'b0, 16'd0}},
    '{KIND_TICK, 8'h00, CHK_PRED,  '{1'b0, 16'd0}},
    '{KIND_TICK, 8'h00, CHK_PRED,  '{1'b0, 16'd0}},
    '{KIND_TICK, 8'h00, CHK_PRED,  '{1'b0, 16'd0}},
    '{KIND_TICK, 8'h00, CHK_PRED,  '{1'b0, 16'd0}},
    '{KIND_TICK, 8'h00, CHK_PRED,  '{1'b0, 16'd0}},
    '{KIND_TICK, 8'h00, CHK_PRED,  '{1'b0, 16'd0}},
    '{KIND_TICK, 8'h00, CHK_PRED,  '{1'b0, 16'd0}},
    '{KIND_TICK, 8'h00, CHK_PULSE, '{1'b0, 16'd6999}},  // stop bit, inverted
    '{KIND_TICK, 8'h00, CHK_PULSE, '{1'b1, 16'd1999}},  // start of the 0xFF frame
    '{KIND_TICK, 8'h00, CHK_PRED,  '{1'b0, 16'd0}}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_kind = KIND_ADD;
  logic [DATA_W-1:0]    in_data_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_line_bit;
  logic [CMP_W-1:0]     out_compare_value;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_BRIGHT;
  logic [CMP_W-1:0]     cfg_wdata = '0;

  framed_byte_bit_fifo_transmitter u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_line_bit      (out_line_bit),
    .out_compare_value (out_compare_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor: the line-bit FIFO with one slot kept free, plus the two
  // compare registers as last written.
  // ---------------------------------------------------------------------
  bit               line_fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] fifo_wr = '0;
  logic [PTR_W-1:0] fifo_rd = '0;
  logic [CMP_W-1:0] bright_cmp = RESET_BRIGHT;
  logic [CMP_W-1:0] dark_cmp   = RESET_DARK;

  pulse_t pending_pulses [$];
  int     mismatches;
  int     cycle_count;

  // Idle control: percent chance per word / per cycle of starting a burst.
  int gap_pct;
  int stall_pct;
  // Each bump asks the receiver for one long hold-off.
  int hold_requests;

  function automatic logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  // A bit that finds the FIFO full is dropped on its own.
  function automatic void push_line_bit(bit b);
    if (next_slot(fifo_wr) == fifo_rd)
      return;
    line_fifo[fifo_wr] = b;
    fifo_wr = next_slot(fifo_wr);
  endfunction

  // 8E1 frame, every bit inverted on the way in.
  function automatic void frame_byte(logic [DATA_W-1:0] data);
    bit parity;
    parity = ^data;
    push_line_bit(1'b1);
    for (int i = 0; i < DATA_W; i++)
      push_line_bit(!data[i]);
    push_line_bit(!parity);
    push_line_bit(1'b0);
  endfunction

  // Empty FIFO: no pulse, nothing changes.
  function automatic bit pop_line_bit(output pulse_t p);
    p = '0;
    if (fifo_wr == fifo_rd)
      return 1'b0;
    p.line_bit      = line_fifo[fifo_rd];
    p.compare_value = line_fifo[fifo_rd] ? bright_cmp : dark_cmp;
    fifo_rd = next_slot(fifo_rd);
    return 1'b1;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("[%0d] mismatch %s: got %0d, want %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Sender. Valid stays high from word to word; it only drops for a gap,
  // so in_valid never sees two assignments in one step.
  // ---------------------------------------------------------------------
  task automatic send_word(logic kind, logic [DATA_W-1:0] data, row_check_t chk,
                           pulse_t typed);
    pulse_t p;
    bit     got;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    // accepted at this edge
    got = 1'b0;
    p   = '0;
    if (kind == KIND_ADD)
      frame_byte(data);
    else
      got = pop_line_bit(p);
    case (chk)
      CHK_PRED: begin
        if (got)
          pending_pulses.push_back(p);
      end
      CHK_NONE: begin
        if (got)
          flag_mismatch("directed row, predictor gives a pulse", 1, 0);
      end
      default: begin
        if (!got || p != typed)
          flag_mismatch("directed row vs predictor", int'(p), int'(typed));
        pending_pulses.push_back(typed);
      end
    endcase
  endtask

  task automatic run_words(int count, int add_pct);
    for (int i = 0; i < count; i++)
      send_word(($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_TICK,
                DATA_W'($urandom_range(0, 255)), CHK_PRED, '0);
  endtask

  // Drain results, then let a trailing add word finish writing its frame.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pulses.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_compare(logic [CFG_IDX_W-1:0] idx, logic [CMP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BRIGHT: bright_cmp = value;
      REG_DARK:   dark_cmp   = value;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, or a long hold-off on request so the block
  // backs up and stalls its input.
  // ---------------------------------------------------------------------
  int holds_taken;
  int hold_left;
  int burst_left;

  always @(posedge clk) begin
    if (hold_requests != holds_taken) begin
      holds_taken++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      burst_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result check against the oldest expected pulse.
  always @(posedge clk) begin
    pulse_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pulses.size() == 0) begin
        flag_mismatch("unexpected word, line_bit", int'(out_line_bit), 0);
      end else begin
        want = pending_pulses.pop_front();
        if (out_line_bit !== want.line_bit)
          flag_mismatch("line_bit", int'(out_line_bit), int'(want.line_bit));
        if (out_compare_value !== want.compare_value)
          flag_mismatch("compare_value", int'(out_compare_value),
                        int'(want.compare_value));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    gap_pct   = 20;
    stall_pct = 20;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty tick, frame extremes, reset compare values.
    for (int r = 0; r < DIR_N; r++)
      send_word(DIR_ROWS[r].kind, DIR_ROWS[r].data_byte, DIR_ROWS[r].chk,
                DIR_ROWS[r].pulse);
    settle();

    // Compare extremes one way; receiver holds off long while words keep coming.
    write_compare(REG_BRIGHT, 16'h0000);
    write_compare(REG_DARK, 16'hFFFF);
    hold_requests++;
    run_words(300, 9);
    settle();

    // Extremes the other way; add-heavy to overflow the FIFO and drop bits,
    // then tick-heavy to drain it and tick on empty.
    write_compare(REG_BRIGHT, 16'hFFFF);
    write_compare(REG_DARK, 16'h0000);
    run_words(250, 40);
    run_words(250, 3);
    settle();

    // Random compare values, a stretch with no idling on the sender.
    write_compare(REG_BRIGHT, CMP_W'($urandom_range(0, 65535)));
    write_compare(REG_DARK, CMP_W'($urandom_range(0, 65535)));
    gap_pct = 0;
    run_words(250, 9);
    settle();

    // Last part: both compares equal, no idling on either side.
    write_compare(REG_BRIGHT, 16'd4242);
    write_compare(REG_DARK, 16'd4242);
    stall_pct = 0;
    run_words(330, 15);
    settle();

    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
